/* sv/sbr_pkg.sv */
package sbr_pkg;

  // Build-time defaults
  localparam int unsigned HUNT_LIMIT_DEF = 20;
  localparam int unsigned HUNT_W         = 5;

  // Configuration port
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 1'b1;

  localparam logic [7:0]  MAX_PAYLOAD_RST = 8'd253;
  localparam logic [15:0] TIMEOUT_RST     = 16'd1000;

  // Command codes
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_BYTE  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_END     = 1'b1;

  // End status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_HEADER = 3'd1;
  localparam logic [2:0] ST_LEN_SHORT = 3'd2;
  localparam logic [2:0] ST_BAD_SUM   = 3'd3;
  localparam logic [2:0] ST_TOO_LONG  = 3'd4;
  localparam logic [2:0] ST_TIMEOUT   = 3'd5;

  // Framing
  localparam logic [7:0] SYNC_BYTE    = 8'hFF;
  localparam logic [7:0] LEN_OVERHEAD = 8'd2;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] packet_id;
    logic [7:0] error_byte;
    logic [7:0] payload_len;
    logic [2:0] status;
  } res_t;

endpackage

/* sv/sbr_in_if.sv */
interface sbr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] rx_byte;

  modport source (output valid, output cmd, output rx_byte, input ready);
  modport sink (input valid, input cmd, input rx_byte, output ready);
endinterface

/* sv/sbr_out_if.sv */
interface sbr_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] payload_byte;
  logic [7:0] payload_index;
  logic [7:0] packet_id;
  logic [7:0] error_byte;
  logic [7:0] payload_len;
  logic [2:0] status;

  modport source (output valid, output kind, output payload_byte, output payload_index,
                  output packet_id, output error_byte, output payload_len, output status,
                  input ready);
  modport sink (input valid, input kind, input payload_byte, input payload_index,
                input packet_id, input error_byte, input payload_len, input status,
                output ready);
endinterface

/* sv/sbr_core.sv */
module sbr_core #(
  parameter int unsigned HUNT_LIMIT = sbr_pkg::HUNT_LIMIT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [1:0]        cmd,
  input  logic [7:0]        rx_byte,
  input  logic [7:0]        max_payload,
  input  logic [15:0]       timeout_ticks,
  output logic              res_valid,
  output sbr_pkg::res_t     res
);
  import sbr_pkg::*;

  localparam logic [HUNT_W-1:0] HuntLim = HUNT_W'(HUNT_LIMIT);

  typedef enum logic [6:0] {
    PH_IDLE = 7'b0000001,
    PH_HUNT = 7'b0000010,
    PH_ID   = 7'b0000100,
    PH_LEN  = 7'b0001000,
    PH_ERR  = 7'b0010000,
    PH_DATA = 7'b0100000,
    PH_SUM  = 7'b1000000
  } phase_t;

  phase_t            phase, phase_next;
  logic [7:0]        previous_byte, previous_byte_next;
  logic [HUNT_W-1:0] hunt_count, hunt_count_next;
  logic [7:0]        held_id, held_id_next;
  logic [7:0]        held_length, held_length_next;
  logic [7:0]        held_error, held_error_next;
  logic [7:0]        running_sum, running_sum_next;
  logic [7:0]        byte_index, byte_index_next;
  logic [15:0]       wait_count, wait_count_next;

  logic [15:0]       wait_inc;
  logic [HUNT_W-1:0] hunt_inc;
  logic [7:0]        idx_inc;
  logic [7:0]        body_len;
  logic              header_hit;
  logic              in_body;

  // Per-beat helpers
  assign wait_inc   = (wait_count == 16'hFFFF) ? wait_count : wait_count + 16'd1;
  assign hunt_inc   = hunt_count + HUNT_W'(1);
  assign idx_inc    = byte_index + 8'd1;
  assign body_len   = held_length - LEN_OVERHEAD;
  assign header_hit = (previous_byte == SYNC_BYTE) && (rx_byte == SYNC_BYTE);
  assign in_body    = (phase == PH_DATA) || (phase == PH_SUM);

  // Next state and result for one beat
  always_comb begin
    phase_next         = phase;
    previous_byte_next = previous_byte;
    hunt_count_next    = hunt_count;
    held_id_next       = held_id;
    held_length_next   = held_length;
    held_error_next    = held_error;
    running_sum_next   = running_sum;
    byte_index_next    = byte_index;
    wait_count_next    = wait_count;

    res_valid         = 1'b0;
    res.kind          = KIND_PAYLOAD;
    res.payload_byte  = '0;
    res.payload_index = '0;
    res.packet_id     = held_id;
    res.error_byte    = held_error;
    res.payload_len   = in_body ? body_len : '0;
    res.status        = ST_OK;

    if (fire) begin
      if (cmd == CMD_START) begin
        phase_next         = PH_HUNT;
        previous_byte_next = '0;
        hunt_count_next    = '0;
        held_id_next       = '0;
        held_length_next   = '0;
        held_error_next    = '0;
        running_sum_next   = '0;
        byte_index_next    = '0;
        wait_count_next    = '0;
      end else if (cmd == CMD_TICK && phase != PH_IDLE) begin
        wait_count_next = wait_inc;
        if (wait_inc >= timeout_ticks) begin
          res_valid  = 1'b1;
          res.kind   = KIND_END;
          res.status = ST_TIMEOUT;
          phase_next = PH_IDLE;
        end
      end else if (cmd == CMD_BYTE && phase != PH_IDLE) begin
        wait_count_next = '0;
        unique case (phase)
          PH_IDLE: ;
          PH_HUNT: begin
            if (header_hit) begin
              phase_next = PH_ID;
            end else begin
              previous_byte_next = rx_byte;
              hunt_count_next    = hunt_inc;
              if (hunt_inc >= HuntLim) begin
                res_valid  = 1'b1;
                res.kind   = KIND_END;
                res.status = ST_NO_HEADER;
                phase_next = PH_IDLE;
              end
            end
          end
          PH_ID: begin
            held_id_next = rx_byte;
            phase_next   = PH_LEN;
          end
          PH_LEN: begin
            held_length_next = rx_byte;
            phase_next       = PH_ERR;
          end
          PH_ERR: begin
            held_error_next = rx_byte;
            if (held_length < LEN_OVERHEAD) begin
              res_valid      = 1'b1;
              res.kind       = KIND_END;
              res.error_byte = rx_byte;
              res.status     = ST_LEN_SHORT;
              phase_next     = PH_IDLE;
            end else begin
              running_sum_next = held_id + held_length + rx_byte;
              byte_index_next  = '0;
              phase_next       = (held_length == LEN_OVERHEAD) ? PH_SUM : PH_DATA;
            end
          end
          PH_DATA: begin
            running_sum_next = running_sum + rx_byte;
            byte_index_next  = idx_inc;
            if (byte_index < max_payload) begin
              res_valid         = 1'b1;
              res.payload_byte  = rx_byte;
              res.payload_index = byte_index;
            end
            if (idx_inc >= body_len) begin
              phase_next = PH_SUM;
            end
          end
          PH_SUM: begin
            res_valid  = 1'b1;
            res.kind   = KIND_END;
            phase_next = PH_IDLE;
            priority if (~running_sum != rx_byte) begin
              res.status = ST_BAD_SUM;
            end else if (body_len > max_payload) begin
              res.status = ST_TOO_LONG;
            end else begin
              res.status = ST_OK;
            end
          end
          default: phase_next = PH_IDLE;
        endcase
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      previous_byte <= '0;
      hunt_count    <= '0;
      held_id       <= '0;
      held_length   <= '0;
      held_error    <= '0;
      running_sum   <= '0;
      byte_index    <= '0;
      wait_count    <= '0;
    end else begin
      phase         <= phase_next;
      previous_byte <= previous_byte_next;
      hunt_count    <= hunt_count_next;
      held_id       <= held_id_next;
      held_length   <= held_length_next;
      held_error    <= held_error_next;
      running_sum   <= running_sum_next;
      byte_index    <= byte_index_next;
      wait_count    <= wait_count_next;
    end
  end

  // Checks
  a_phase_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(phase))
    else $error("phase register lost its one-hot code");

  a_end_goes_idle: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.kind == KIND_END) |=> (phase == PH_IDLE))
    else $error("end result not followed by idle");

  a_hunt_below_limit: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HUNT) |-> (hunt_count < HuntLim))
    else $error("hunt count reached limit while still hunting");

  a_payload_index: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.kind == KIND_PAYLOAD) |->
      (res.payload_index < max_payload && phase == PH_DATA))
    else $error("payload beat outside data phase or beyond max payload");

endmodule

/* sv/servo_bus_status_packet_receiver.sv */
// Path: an accepted beat passes the input register, the core step logic and then
//   the result register; the per-beat state update is one pass of logic.
// Throughput: one beat per cycle while the result slot is free or being drained.
// Reset (rst, synchronous, active high): receiver idle, packet state cleared,
//   max_payload = 253, timeout_ticks = 1000, both stages empty.
module servo_bus_status_packet_receiver #(
  parameter int unsigned HUNT_LIMIT = sbr_pkg::HUNT_LIMIT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  sbr_in_if.sink                          item,
  sbr_out_if.source                       result,
  input  logic                            cfg_we,
  input  logic [sbr_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [sbr_pkg::CFG_W-1:0]       cfg_data
);
  import sbr_pkg::*;

  logic [7:0]  max_payload;
  logic [15:0] timeout_ticks;

  logic        q_valid;
  logic [1:0]  q_cmd;
  logic [7:0]  q_byte;
  logic        advance;
  logic        fire;

  logic        step_valid;
  res_t        step_res;
  logic        out_valid;
  res_t        out_res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload   <= MAX_PAYLOAD_RST;
      timeout_ticks <= TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_MAX_PAYLOAD: max_payload   <= cfg_data[7:0];
        CFG_TIMEOUT:     timeout_ticks <= cfg_data;
      endcase
    end
  end

  // Handshake: the step runs when the result slot is free or being drained
  assign advance    = !out_valid || result.ready;
  assign fire       = q_valid && advance;
  assign item.ready = !q_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (item.ready) begin
      q_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      q_cmd  <= item.cmd;
      q_byte <= item.rx_byte;
    end
  end

  sbr_core #(
    .HUNT_LIMIT(HUNT_LIMIT)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .cmd          (q_cmd),
    .rx_byte      (q_byte),
    .max_payload  (max_payload),
    .timeout_ticks(timeout_ticks),
    .res_valid    (step_valid),
    .res          (step_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= fire && step_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && fire && step_valid) begin
      out_res <= step_res;
    end
  end

  assign result.valid         = out_valid;
  assign result.kind          = out_res.kind;
  assign result.payload_byte  = out_res.payload_byte;
  assign result.payload_index = out_res.payload_index;
  assign result.packet_id     = out_res.packet_id;
  assign result.error_byte    = out_res.error_byte;
  assign result.payload_len   = out_res.payload_len;
  assign result.status        = out_res.status;

endmodule
